/* rtl/assert_macros.svh */
// assertion macros shared by the rtl modules
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TGA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define TGA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TGA_ASSERT(lbl, clk, rst, prop)
`define TGA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/tga_pkg.sv */
// types and constants of the tga stream decoder
// no dependencies
package tga_pkg;

   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [1:0] ERR_TYPE  = 2'd0;
   localparam logic [1:0] ERR_DEPTH = 2'd1;
   localparam logic [1:0] ERR_TRUNC = 2'd2;

   localparam logic [1:0] FMT_I8     = 2'd0;
   localparam logic [1:0] FMT_RGB5A1 = 2'd1;
   localparam logic [1:0] FMT_RGB888 = 2'd2;
   localparam logic [1:0] FMT_RGBA   = 2'd3;

   localparam logic [7:0] TYPE_TRUE = 8'd2;
   localparam logic [7:0] TYPE_GREY = 8'd3;
   localparam logic [7:0] TYPE_RLE  = 8'd10;

   localparam logic [7:0] DEPTH_8  = 8'd8;
   localparam logic [7:0] DEPTH_16 = 8'd16;
   localparam logic [7:0] DEPTH_24 = 8'd24;
   localparam logic [7:0] DEPTH_32 = 8'd32;

   localparam logic [4:0] IDX_TYPE   = 5'd2;
   localparam logic [4:0] IDX_WID_LO = 5'd12;
   localparam logic [4:0] IDX_WID_HI = 5'd13;
   localparam logic [4:0] IDX_HGT_LO = 5'd14;
   localparam logic [4:0] IDX_HGT_HI = 5'd15;
   localparam logic [4:0] IDX_DEPTH  = 5'd16;
   localparam logic [4:0] IDX_LAST   = 5'd17;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] pixel;
      logic [7:0]  repeat_count;
      logic [1:0]  pixel_format;
      logic [14:0] image_width;
      logic [14:0] image_height;
      logic [1:0]  error_code;
      logic        last;
   } rsp_type;

endpackage

/* rtl/tga_ifs.sv */
// request and response channel interfaces of the tga stream decoder
// no dependencies
interface tga_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;
   modport source(output valid, output data_byte, output end_of_file, input ready);
   modport sink(input valid, input data_byte, input end_of_file, output ready);
endinterface

interface tga_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] pixel;
   logic [7:0]  repeat_count;
   logic [1:0]  pixel_format;
   logic [14:0] image_width;
   logic [14:0] image_height;
   logic [1:0]  error_code;
   logic        last;
   modport source(output valid, output kind, output pixel, output repeat_count,
                  output pixel_format, output image_width, output image_height,
                  output error_code, output last, input ready);
   modport sink(input valid, input kind, input pixel, input repeat_count,
                input pixel_format, input image_width, input image_height,
                input error_code, input last, output ready);
endinterface

/* rtl/tga_front.sv */
// front end: accepts file bytes, parses the header and rle packets, builds results
// depends on tga_pkg, tga_ifs, assert_macros.svh
`include "assert_macros.svh"
module tga_front (
   input  logic             clock,
   input  logic             reset,
   tga_req_if.sink          req_chan,
   input  logic             q_ready,
   output logic             q_push,
   output tga_pkg::rsp_type q_data
);

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_PIXELS = 2'd1;
   localparam logic [1:0] PH_PACKET = 2'd2;
   localparam logic [1:0] PH_SKIP   = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [4:0]  hidx_ff, hidx_in;
   logic [7:0]  itype_ff, itype_in;
   logic [7:0]  bpp_ff, bpp_in;
   logic [14:0] wid_ff, wid_in;
   logic [14:0] hgt_ff, hgt_in;
   logic [29:0] total_ff, total_in;
   logic [29:0] pleft_ff, pleft_in;
   logic [6:0]  pkl_ff, pkl_in;
   logic        run_ff, run_in;
   logic [1:0]  bip_ff, bip_in;
   logic [31:0] acc_ff, acc_in;

   logic        accept;
   logic [7:0]  b;
   logic        eof;
   logic        type_ok, depth_ok;
   logic [1:0]  fmt;
   logic [4:0]  nbytes;
   logic [31:0] acc_new, pix;
   logic [7:0]  rep;
   logic [29:0] pleft_new;

   assign req_chan.ready = q_ready;
   assign accept = req_chan.valid & q_ready;
   assign b      = req_chan.data_byte;
   assign eof    = req_chan.end_of_file;

   always_comb begin
      type_ok = (itype_ff == tga_pkg::TYPE_TRUE) || (itype_ff == tga_pkg::TYPE_GREY)
             || (itype_ff == tga_pkg::TYPE_RLE);
      if (itype_ff == tga_pkg::TYPE_GREY) begin
         depth_ok = (bpp_ff == tga_pkg::DEPTH_8);
         fmt      = tga_pkg::FMT_I8;
      end else begin
         depth_ok = (bpp_ff == tga_pkg::DEPTH_16) || (bpp_ff == tga_pkg::DEPTH_24)
                 || (bpp_ff == tga_pkg::DEPTH_32);
         fmt = (bpp_ff == tga_pkg::DEPTH_16) ? tga_pkg::FMT_RGB5A1 :
               (bpp_ff == tga_pkg::DEPTH_24) ? tga_pkg::FMT_RGB888 : tga_pkg::FMT_RGBA;
      end
      nbytes  = bpp_ff[7:3];
      acc_new = acc_ff | ({24'b0, b} << {bip_ff, 3'b000});
      pix     = acc_new;
      if (nbytes >= 5'd3) begin
         pix = {acc_new[31:24], acc_new[7:0], acc_new[15:8], acc_new[23:16]};
      end
      rep = ((itype_ff == tga_pkg::TYPE_RLE) && run_ff) ? ({1'b0, pkl_ff} + 8'd1) : 8'd1;
      if ({22'b0, rep} > pleft_ff) begin
         rep = pleft_ff[7:0];
      end
      pleft_new = pleft_ff - {22'b0, rep};
   end

   always_comb begin
      phase_in = phase_ff;
      hidx_in  = hidx_ff;
      itype_in = itype_ff;
      bpp_in   = bpp_ff;
      wid_in   = wid_ff;
      hgt_in   = hgt_ff;
      total_in = total_ff;
      pleft_in = pleft_ff;
      pkl_in   = pkl_ff;
      run_in   = run_ff;
      bip_in   = bip_ff;
      acc_in   = acc_ff;
      q_push   = 1'b0;
      q_data   = '0;
      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               case (hidx_ff)
                  tga_pkg::IDX_TYPE:   itype_in = b;
                  tga_pkg::IDX_WID_LO: wid_in[7:0] = b;
                  tga_pkg::IDX_WID_HI: wid_in[14:8] = b[6:0];
                  tga_pkg::IDX_HGT_LO: hgt_in[7:0] = b;
                  tga_pkg::IDX_HGT_HI: hgt_in[14:8] = b[6:0];
                  tga_pkg::IDX_DEPTH: begin
                     bpp_in   = b;
                     total_in = 30'(wid_ff) * 30'(hgt_ff);
                  end
                  default: ;
               endcase
               if (hidx_ff >= tga_pkg::IDX_LAST) begin
                  q_push = 1'b1;
                  q_data.last = 1'b1;
                  if (!type_ok) begin
                     q_data.kind       = tga_pkg::KIND_ERROR;
                     q_data.error_code = tga_pkg::ERR_TYPE;
                     phase_in = PH_SKIP;
                  end else if (!depth_ok) begin
                     q_data.kind       = tga_pkg::KIND_ERROR;
                     q_data.error_code = tga_pkg::ERR_DEPTH;
                     phase_in = PH_SKIP;
                  end else if (total_ff == '0) begin
                     q_data.kind         = tga_pkg::KIND_HEADER;
                     q_data.pixel_format = fmt;
                     q_data.image_width  = wid_ff;
                     q_data.image_height = hgt_ff;
                     phase_in = PH_SKIP;
                  end else if (eof) begin
                     q_data.kind       = tga_pkg::KIND_ERROR;
                     q_data.error_code = tga_pkg::ERR_TRUNC;
                  end else begin
                     q_data.kind         = tga_pkg::KIND_HEADER;
                     q_data.pixel_format = fmt;
                     q_data.image_width  = wid_ff;
                     q_data.image_height = hgt_ff;
                     q_data.last         = 1'b0;
                     pleft_in = total_ff;
                     bip_in   = '0;
                     acc_in   = '0;
                     run_in   = 1'b0;
                     pkl_in   = '0;
                     phase_in = (itype_ff == tga_pkg::TYPE_RLE) ? PH_PACKET : PH_PIXELS;
                  end
               end else begin
                  hidx_in = hidx_ff + 5'd1;
                  if (eof) begin
                     q_push            = 1'b1;
                     q_data.kind       = tga_pkg::KIND_ERROR;
                     q_data.error_code = tga_pkg::ERR_TRUNC;
                     q_data.last       = 1'b1;
                  end
               end
            end
            PH_PACKET: begin
               run_in   = b[7];
               pkl_in   = b[6:0];
               bip_in   = '0;
               acc_in   = '0;
               phase_in = PH_PIXELS;
               if (eof) begin
                  q_push            = 1'b1;
                  q_data.kind       = tga_pkg::KIND_ERROR;
                  q_data.error_code = tga_pkg::ERR_TRUNC;
                  q_data.last       = 1'b1;
               end
            end
            PH_PIXELS: begin
               if ({3'b0, bip_ff} + 5'd1 >= nbytes) begin
                  q_push   = 1'b1;
                  pleft_in = pleft_new;
                  bip_in   = '0;
                  acc_in   = '0;
                  if (pleft_new == '0) begin
                     q_data.kind         = tga_pkg::KIND_PIXEL;
                     q_data.pixel        = pix;
                     q_data.repeat_count = rep;
                     q_data.last         = 1'b1;
                     phase_in = PH_SKIP;
                  end else if (eof) begin
                     q_data.kind       = tga_pkg::KIND_ERROR;
                     q_data.error_code = tga_pkg::ERR_TRUNC;
                     q_data.last       = 1'b1;
                  end else begin
                     q_data.kind         = tga_pkg::KIND_PIXEL;
                     q_data.pixel        = pix;
                     q_data.repeat_count = rep;
                     if (itype_ff == tga_pkg::TYPE_RLE) begin
                        if (run_ff || (pkl_ff == '0)) begin
                           phase_in = PH_PACKET;
                        end else begin
                           pkl_in = pkl_ff - 7'd1;
                        end
                     end
                  end
               end else begin
                  bip_in = bip_ff + 2'd1;
                  acc_in = acc_new;
                  if (eof) begin
                     q_push            = 1'b1;
                     q_data.kind       = tga_pkg::KIND_ERROR;
                     q_data.error_code = tga_pkg::ERR_TRUNC;
                     q_data.last       = 1'b1;
                  end
               end
            end
            default: ;
         endcase
         if (eof) begin
            phase_in = PH_HEADER;
            hidx_in  = '0;
            itype_in = '0;
            bpp_in   = '0;
            wid_in   = '0;
            hgt_in   = '0;
            total_in = '0;
            pleft_in = '0;
            pkl_in   = '0;
            run_in   = 1'b0;
            bip_in   = '0;
            acc_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         hidx_ff  <= '0;
         itype_ff <= '0;
         bpp_ff   <= '0;
         wid_ff   <= '0;
         hgt_ff   <= '0;
         total_ff <= '0;
         pleft_ff <= '0;
         pkl_ff   <= '0;
         run_ff   <= 1'b0;
         bip_ff   <= '0;
         acc_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         hidx_ff  <= hidx_in;
         itype_ff <= itype_in;
         bpp_ff   <= bpp_in;
         wid_ff   <= wid_in;
         hgt_ff   <= hgt_in;
         total_ff <= total_in;
         pleft_ff <= pleft_in;
         pkl_ff   <= pkl_in;
         run_ff   <= run_in;
         bip_ff   <= bip_in;
         acc_ff   <= acc_in;
      end
   end

   `TGA_ASSERT(a_err_is_last, clock, reset, (q_push && (q_data.kind == tga_pkg::KIND_ERROR)) |-> q_data.last)
   `TGA_ASSERT(a_eof_rewinds, clock, reset, (accept && eof) |=> ((phase_ff == PH_HEADER) && (hidx_ff == '0)))
   `TGA_ASSERT(a_push_when_room, clock, reset, q_push |-> q_ready)

endmodule

/* rtl/tga_back.sv */
// back end: two-entry queue of results and the response output register
// depends on tga_pkg, tga_ifs, assert_macros.svh
`include "assert_macros.svh"
module tga_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_push,
   input  tga_pkg::rsp_type q_data,
   output logic             q_ready,
   tga_rsp_if.source        rsp_chan
);

   tga_pkg::rsp_type slot_ff [2];
   tga_pkg::rsp_type out_ff;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             out_valid_ff, out_valid_in;
   logic             load;

   assign q_ready = (count_ff != 2'd2);
   assign load    = (count_ff != 2'd0) && (!out_valid_ff || rsp_chan.ready);

   always_comb begin
      wr_ptr_in    = wr_ptr_ff ^ q_push;
      rd_ptr_in    = rd_ptr_ff ^ load;
      count_in     = count_ff + {1'b0, q_push} - {1'b0, load};
      out_valid_in = load ? 1'b1 : (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= 1'b0;
         rd_ptr_ff    <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         slot_ff[wr_ptr_ff] <= q_data;
      end
      if (load) begin
         out_ff <= slot_ff[rd_ptr_ff];
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.kind         = out_ff.kind;
   assign rsp_chan.pixel        = out_ff.pixel;
   assign rsp_chan.repeat_count = out_ff.repeat_count;
   assign rsp_chan.pixel_format = out_ff.pixel_format;
   assign rsp_chan.image_width  = out_ff.image_width;
   assign rsp_chan.image_height = out_ff.image_height;
   assign rsp_chan.error_code   = out_ff.error_code;
   assign rsp_chan.last         = out_ff.last;

   `TGA_ASSERT(a_count_bound, clock, reset, count_ff != 2'd3)
   `TGA_ASSERT(a_no_overflow, clock, reset, q_push |-> (count_ff != 2'd2))
   `TGA_ASSERT(a_ptr_gap, clock, reset, (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))

endmodule

/* rtl/tga_image_stream_decoder.sv */
// top level of the tga stream decoder
// depends on tga_pkg, tga_ifs, tga_front, tga_back
//
// req_chan carries one byte of a tga file per request, with end_of_file set
// on the final byte. rsp_chan returns results: one header result after byte
// 17 of the header, then one pixel result per decoded pixel or rle run, or an
// error result that ends the image. last marks the final result.
// a byte is taken every cycle while the two-entry result queue has room; the
// front end parses one byte per cycle while the queue has room; a result is
// written into a queue slot and then loaded into the output register, where
// rsp_chan.valid rises and the result waits for the receiver.
// sustained rate is one byte per cycle while the result queue has room;
// the image size product is computed at the depth byte and registered.
// reset returns the parser to the start of a header and empties the queue.
// when rsp_chan stalls, the output register holds its result and the queue
// absorbs up to two more; req_chan.ready then drops until a slot frees.
// end_of_file always rewinds the parser for the next file.
module tga_image_stream_decoder (
   input  logic      clock,
   input  logic      reset,
   tga_req_if.sink   req_chan,
   tga_rsp_if.source rsp_chan
);

   logic             q_push;
   logic             q_ready;
   tga_pkg::rsp_type q_data;

   tga_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_ready  (q_ready),
      .q_push   (q_push),
      .q_data   (q_data)
   );

   tga_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_data   (q_data),
      .q_ready  (q_ready),
      .rsp_chan (rsp_chan)
   );

endmodule
